/* rtl/u2c_pkg.sv */
`timescale 1ns / 1ps
// u2c_pkg: widths, calendar constants and reciprocal multipliers for the
// unix time to calendar pipeline; no dependencies

package u2c_pkg;

	// field widths
	localparam int unsigned TS_W    = 32;
	localparam int unsigned DAYS_W  = 16;
	localparam int unsigned SOD_W   = 17;
	localparam int unsigned DOE_W   = 18;
	localparam int unsigned YOE_W   = 9;
	localparam int unsigned DOY_W   = 9;
	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned WDAY_W  = 3;
	localparam int unsigned MKT_W   = 3;

	// calendar constants
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [16:0] HALF_DAY     = 17'd43200;
	localparam logic [19:0] MARCH_SHIFT  = 20'd719468;
	localparam logic [19:0] ERA_DAYS     = 20'd146097;

	// pipeline depth from input to output register
	localparam int unsigned LAT = 8;

	// exact floor division by constants: q = (x * ceil(2^K / D)) >> K,
	// with K = bits of x plus bits of D

	// days = (ts >> 7) / 675
	localparam int unsigned DAY_K   = 35;
	localparam longint unsigned DAY_DIV = 675;
	localparam logic [25:0] DAY_MUL = 26'(((64'd1 << DAY_K) + DAY_DIV - 64'd1) / DAY_DIV);

	// hour = (sod >> 4) / 225
	localparam int unsigned HOUR_K   = 21;
	localparam longint unsigned HOUR_DIV = 225;
	localparam logic [13:0] HOUR_MUL = 14'(((64'd1 << HOUR_K) + HOUR_DIV - 64'd1) / HOUR_DIV);

	// minute = (rest_of_hour >> 2) / 15
	localparam int unsigned MIN_K   = 14;
	localparam longint unsigned MIN_DIV = 15;
	localparam logic [10:0] MIN_MUL = 11'(((64'd1 << MIN_K) + MIN_DIV - 64'd1) / MIN_DIV);

	// weekday and market day quotients of 16-bit values
	localparam int unsigned WEEK_K  = 19;
	localparam longint unsigned WEEK_DIV = 7;
	localparam logic [16:0] WEEK_MUL = 17'(((64'd1 << WEEK_K) + WEEK_DIV - 64'd1) / WEEK_DIV);
	localparam int unsigned MKT_K   = 19;
	localparam longint unsigned MKT_DIV = 5;
	localparam logic [16:0] MKT_MUL = 17'(((64'd1 << MKT_K) + MKT_DIV - 64'd1) / MKT_DIV);

	// doe / 1460 as (doe >> 2) / 365
	localparam int unsigned Q4Y_K   = 25;
	localparam longint unsigned YEAR_DIV = 365;
	localparam logic [16:0] Q4Y_MUL = 17'(((64'd1 << Q4Y_K) + YEAR_DIV - 64'd1) / YEAR_DIV);

	// year of era = t / 365, t below 2^18
	localparam int unsigned YOE_K   = 27;
	localparam logic [18:0] YOE_MUL = 19'(((64'd1 << YOE_K) + YEAR_DIV - 64'd1) / YEAR_DIV);

	// first day of each march-based month within the year
	localparam logic [8:0] MONTH_START [0:11] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};

endpackage

/* rtl/u2c_civil.sv */
`timescale 1ns / 1ps
// u2c_civil: six-stage civil-from-days pipeline (day count to year, month, day)
// depends on u2c_pkg

module u2c_civil import u2c_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [DAYS_W-1:0]   days,
	output logic [YEAR_W-1:0]   year,
	output logic [MONTH_W-1:0]  month,
	output logic [DAY_W-1:0]    day
);

	// stage 3: shift to march epoch, split off the era
	logic [19:0]       z;
	logic              era_hi;
	logic [DOE_W-1:0]  doe_s3;
	logic              era_s3;

	assign z      = 20'(days) + MARCH_SHIFT;
	assign era_hi = (z >= 20'(5 * ERA_DAYS));

	always_ff @(posedge clk) begin
		if (en) begin
			doe_s3 <= DOE_W'(z - (era_hi ? 20'(5 * ERA_DAYS) : 20'(4 * ERA_DAYS)));
			era_s3 <= era_hi;
		end
	end

	// stage 4: four-year and century corrections
	logic [32:0]       q4y_prod;
	logic [1:0]        cent_adj;
	logic [DOE_W-1:0]  doe_s4;
	logic              era_s4;
	logic [6:0]        q4y_s4;
	logic [1:0]        adj_s4;

	assign q4y_prod = 33'(doe_s3[DOE_W-1:2]) * 33'(Q4Y_MUL);
	// doe/36524 - doe/146096 equals the count of the first three century marks
	assign cent_adj = 2'(doe_s3 >= 18'd36524) + 2'(doe_s3 >= 18'd73048)
	                + 2'(doe_s3 >= 18'd109572);

	always_ff @(posedge clk) begin
		if (en) begin
			doe_s4 <= doe_s3;
			era_s4 <= era_s3;
			q4y_s4 <= q4y_prod[Q4Y_K +: 7];
			adj_s4 <= cent_adj;
		end
	end

	// stage 5: leap-corrected day of era
	logic [DOE_W-1:0]  t_s5;
	logic [DOE_W-1:0]  doe_s5;
	logic              era_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s5   <= DOE_W'(doe_s4 - DOE_W'(q4y_s4) + DOE_W'(adj_s4));
			doe_s5 <= doe_s4;
			era_s5 <= era_s4;
		end
	end

	// stage 6: year of era
	logic [36:0]       yoe_prod;
	logic [YOE_W-1:0]  yoe_s6;
	logic [DOE_W-1:0]  doe_s6;
	logic              era_s6;

	assign yoe_prod = 37'(t_s5) * 37'(YOE_MUL);

	always_ff @(posedge clk) begin
		if (en) begin
			yoe_s6 <= yoe_prod[YOE_K +: YOE_W];
			doe_s6 <= doe_s5;
			era_s6 <= era_s5;
		end
	end

	// stage 7: day of year
	logic [1:0]        c100;
	logic [DOE_W-1:0]  year_base;
	logic [DOY_W-1:0]  doy_s7;
	logic [YOE_W-1:0]  yoe_s7;
	logic              era_s7;

	assign c100 = 2'(yoe_s6 >= 9'd100) + 2'(yoe_s6 >= 9'd200) + 2'(yoe_s6 >= 9'd300);
	assign year_base = DOE_W'(yoe_s6) * DOE_W'(365) + DOE_W'(yoe_s6[YOE_W-1:2])
	                 - DOE_W'(c100);

	always_ff @(posedge clk) begin
		if (en) begin
			doy_s7 <= DOY_W'(doe_s6 - year_base);
			yoe_s7 <= yoe_s6;
			era_s7 <= era_s6;
		end
	end

	// stage 8: month lookup, day of month and final year
	logic [3:0]        mp;
	logic              jan_feb;
	logic [YEAR_W-1:0] era_base;

	always_comb begin
		mp = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s7 >= MONTH_START[i]) begin
				mp = 4'(i);
			end
		end
	end

	assign jan_feb  = (mp >= 4'd10);
	assign era_base = era_s7 ? 12'd2000 : 12'd1600;

	always_ff @(posedge clk) begin
		if (en) begin
			day   <= DAY_W'(doy_s7 - MONTH_START[mp] + 9'd1);
			month <= jan_feb ? MONTH_W'(mp - 4'd9) : MONTH_W'(mp + 4'd3);
			year  <= YEAR_W'(YEAR_W'(yoe_s7) + era_base + YEAR_W'(jan_feb));
		end
	end

endmodule

/* rtl/u2c_tod.sv */
`timescale 1ns / 1ps
// u2c_tod: six-stage time-of-day, weekday and market day pipeline
// depends on u2c_pkg

module u2c_tod import u2c_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [SOD_W-1:0]    sod,
	input  logic [DAYS_W-1:0]   days,
	output logic [HOUR_W-1:0]   hour,
	output logic [MIN_W-1:0]    minute,
	output logic [SEC_W-1:0]    second,
	output logic [WDAY_W-1:0]   weekday,
	output logic [MKT_W-1:0]    market_day
);

	// stage 3: hour and cycle quotients
	logic [26:0]        hour_prod;
	logic               pm;
	logic [DAYS_W-1:0]  wx;
	logic [DAYS_W-1:0]  mx;
	logic [32:0]        wq_prod;
	logic [32:0]        mq_prod;
	logic [SOD_W-1:0]   sod_s3;
	logic [HOUR_W-1:0]  hour_s3;
	logic [DAYS_W-1:0]  wx_s3;
	logic [DAYS_W-1:0]  mx_s3;
	logic [12:0]        wq_s3;
	logic [13:0]        mq_s3;

	assign hour_prod = 27'(sod[SOD_W-1:4]) * 27'(HOUR_MUL);
	// the julian day turns at noon, so the afternoon counts one more step
	assign pm      = (sod >= HALF_DAY);
	assign wx      = DAYS_W'(days + 16'd4);
	assign mx      = DAYS_W'(days + 16'd2 + 16'(pm));
	assign wq_prod = 33'(wx) * 33'(WEEK_MUL);
	assign mq_prod = 33'(mx) * 33'(MKT_MUL);

	always_ff @(posedge clk) begin
		if (en) begin
			sod_s3  <= sod;
			hour_s3 <= hour_prod[HOUR_K +: HOUR_W];
			wx_s3   <= wx;
			mx_s3   <= mx;
			wq_s3   <= wq_prod[WEEK_K +: 13];
			mq_s3   <= mq_prod[MKT_K +: 14];
		end
	end

	// stage 4: remainders
	logic [11:0]        ms_s4;
	logic [HOUR_W-1:0]  hour_s4;
	logic [WDAY_W-1:0]  wday_s4;
	logic [MKT_W-1:0]   mkt_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ms_s4   <= 12'(sod_s3 - SOD_W'(hour_s3) * SOD_W'(3600));
			hour_s4 <= hour_s3;
			wday_s4 <= WDAY_W'(wx_s3 - DAYS_W'(wq_s3) * DAYS_W'(7));
			mkt_s4  <= MKT_W'(mx_s3 - DAYS_W'(mq_s3) * DAYS_W'(5));
		end
	end

	// stage 5: minute
	logic [20:0]        min_prod;
	logic [11:0]        ms_s5;
	logic [MIN_W-1:0]   min_s5;
	logic [HOUR_W-1:0]  hour_s5;
	logic [WDAY_W-1:0]  wday_s5;
	logic [MKT_W-1:0]   mkt_s5;

	assign min_prod = 21'(ms_s4[11:2]) * 21'(MIN_MUL);

	always_ff @(posedge clk) begin
		if (en) begin
			ms_s5   <= ms_s4;
			min_s5  <= min_prod[MIN_K +: MIN_W];
			hour_s5 <= hour_s4;
			wday_s5 <= wday_s4;
			mkt_s5  <= mkt_s4;
		end
	end

	// stage 6: second
	logic [SEC_W-1:0]   sec_s6;
	logic [MIN_W-1:0]   min_s6;
	logic [HOUR_W-1:0]  hour_s6;
	logic [WDAY_W-1:0]  wday_s6;
	logic [MKT_W-1:0]   mkt_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s6  <= SEC_W'(ms_s5 - 12'(min_s5) * 12'(60));
			min_s6  <= min_s5;
			hour_s6 <= hour_s5;
			wday_s6 <= wday_s5;
			mkt_s6  <= mkt_s5;
		end
	end

	// stage 7: align with the date path
	logic [SEC_W-1:0]   sec_s7;
	logic [MIN_W-1:0]   min_s7;
	logic [HOUR_W-1:0]  hour_s7;
	logic [WDAY_W-1:0]  wday_s7;
	logic [MKT_W-1:0]   mkt_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s7  <= sec_s6;
			min_s7  <= min_s6;
			hour_s7 <= hour_s6;
			wday_s7 <= wday_s6;
			mkt_s7  <= mkt_s6;
		end
	end

	// stage 8: output register
	always_ff @(posedge clk) begin
		if (en) begin
			second     <= sec_s7;
			minute     <= min_s7;
			hour       <= hour_s7;
			weekday    <= wday_s7;
			market_day <= mkt_s7;
		end
	end

endmodule

/* rtl/unix_time_to_calendar_top.sv */
`timescale 1ns / 1ps
// unix_time_to_calendar_top: stream wrapper, day split and valid pipeline
// depends on u2c_pkg, u2c_civil and u2c_tod
//
// Converts a 32-bit unsigned unix timestamp into UTC calendar date, time of
// day, weekday (0 Sunday) and five-day market index.
// Input channel s_*: one timestamp per item in s_tdata.
// Output channel m_*: one result item per input item, in the same order.
// Eight register stages, stage 1 to stage 8; m_tvalid is the valid bit of
// stage 8. Throughput is one item per cycle while m_tready does not stall the
// output: the pipeline holds eight items in flight, and the divisions by
// constants are reciprocal multiplies spread over the stages.
// The whole pipeline advances together; when m_tvalid is high and m_tready
// low, every stage holds and s_tready drops in the same cycle, so nothing
// is lost or repeated. Bubbles move through with the items.
// Reset clears only the valid bits; the data registers are not reset, and
// the block is ready for an item as soon as reset is released.

module unix_time_to_calendar_top import u2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] unix_seconds
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // year, month, day, hour, minute, second,
	                               // weekday, market_day, zero pad
);

	logic           adv;
	logic [LAT-1:0] vld_q;

	// the pipeline moves unless the output item is stalled
	assign adv      = !vld_q[LAT-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT-1];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// stage 1: day count by reciprocal of 675 on ts >> 7
	logic [50:0]        day_prod;
	logic [TS_W-1:0]    ts_s1;
	logic [DAYS_W-1:0]  days_s1;

	assign day_prod = 51'(s_tdata[TS_W-1:7]) * 51'(DAY_MUL);

	always_ff @(posedge clk) begin
		if (adv) begin
			ts_s1   <= s_tdata;
			days_s1 <= day_prod[DAY_K +: DAYS_W];
		end
	end

	// stage 2: second of day
	logic [DAYS_W-1:0]  days_s2;
	logic [SOD_W-1:0]   sod_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			days_s2 <= days_s1;
			sod_s2  <= SOD_W'(ts_s1 - TS_W'(days_s1) * TS_W'(SECS_PER_DAY));
		end
	end

	// stages 3 to 8
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DAY_W-1:0]   day;
	logic [HOUR_W-1:0]  hour;
	logic [MIN_W-1:0]   minute;
	logic [SEC_W-1:0]   second;
	logic [WDAY_W-1:0]  weekday;
	logic [MKT_W-1:0]   market_day;

	u2c_civil u_civil (
		.clk   (clk),
		.en    (adv),
		.days  (days_s2),
		.year  (year),
		.month (month),
		.day   (day)
	);

	u2c_tod u_tod (
		.clk        (clk),
		.en         (adv),
		.sod        (sod_s2),
		.days       (days_s2),
		.hour       (hour),
		.minute     (minute),
		.second     (second),
		.weekday    (weekday),
		.market_day (market_day)
	);

	// pack the result item
	assign m_tdata = {4'd0, market_day, weekday, second, minute, hour, day, month, year};

endmodule
